// ===== hdl/salc_pkg.sv =====
`default_nettype none
package salc_pkg;

  localparam int unsigned DEF_MAX_SET_BITS = 8;
  localparam int unsigned DEF_MAX_WAYS     = 8;
  localparam int unsigned DEF_ADDR_WIDTH   = 64;

  localparam int unsigned KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OUT_BITS   = 2 + 3 * CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  localparam int unsigned SET_BITS_W = 4;
  localparam int unsigned WAYS_W     = 4;
  localparam int unsigned OFF_W      = 6;

  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WAYS_USED   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lookup_res_t;

endpackage
`default_nettype wire

// ===== hdl/salc_addr_split.sv =====
`default_nettype none
module salc_addr_split #(
  parameter int unsigned ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [ADDR_WIDTH-1:0]              address,
  input  logic [salc_pkg::OFF_W-1:0]         offset_bits,
  input  logic [salc_pkg::SET_BITS_W-1:0]    set_bits_eff,
  output logic [SET_W-1:0]                   set_idx,
  output logic [ADDR_WIDTH-1:0]              tag
);

  logic [ADDR_WIDTH-1:0] blk;

  // shifts of the full width or more give zero
  assign blk = address >> offset_bits;
  assign tag = blk >> set_bits_eff;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_idx[i] = (i < int'(set_bits_eff)) ? blk[i] : 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/salc_set_mem.sv =====
`default_nettype none
module salc_set_mem #(
  parameter int unsigned ADDR_W = salc_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned DEPTH  = 2 ** salc_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/salc_way_logic.sv =====
`default_nettype none
module salc_way_logic #(
  parameter int unsigned ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH,
  parameter int unsigned MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
  parameter int unsigned W_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int unsigned WCNT_W     = $clog2(MAX_WAYS + 1)
) (
  input  logic [MAX_WAYS-1:0]                 row_valid,
  input  logic [MAX_WAYS-1:0][W_W-1:0]        row_rank,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] row_tag,
  input  logic [ADDR_WIDTH-1:0]               tag,
  input  logic [WCNT_W-1:0]                   ways_eff,
  output logic [MAX_WAYS-1:0]                 new_valid,
  output logic [MAX_WAYS-1:0][W_W-1:0]        new_rank,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag,
  output salc_pkg::lookup_res_t               res
);

  logic           hit;
  logic           found_free;
  logic [W_W-1:0] hit_way;
  logic [W_W-1:0] free_way;
  logic [W_W-1:0] lru_way;
  logic [W_W-1:0] victim;
  logic           old_valid;
  logic [W_W-1:0] old_rank;

  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    found_free = 1'b0;
    free_way   = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(ways_eff) && row_valid[w] && row_tag[w] == tag) begin
        hit     = 1'b1;
        hit_way = W_W'(w);
      end
      if (w < int'(ways_eff) && !row_valid[w]) begin
        found_free = 1'b1;
        free_way   = W_W'(w);
      end
    end
  end

  // oldest way, lowest index on a tie
  always_comb begin
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (w < int'(ways_eff) && row_rank[w] > row_rank[lru_way]) begin
        lru_way = W_W'(w);
      end
    end
  end

  always_comb begin
    priority if (hit) begin
      victim = hit_way;
    end else if (found_free) begin
      victim = free_way;
    end else begin
      victim = lru_way;
    end
  end

  assign old_valid   = row_valid[victim];
  assign old_rank    = row_rank[victim];
  assign res.hit     = hit;
  assign res.evicted = !hit && !found_free;

  always_comb begin
    new_valid = row_valid;
    new_tag   = row_tag;
    new_rank  = row_rank;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (W_W'(j) == victim) begin
        new_rank[j] = '0;
      end else if (j < int'(ways_eff) && row_valid[j] &&
                   (!old_valid || row_rank[j] < old_rank) &&
                   int'(row_rank[j]) < MAX_WAYS - 1) begin
        new_rank[j] = row_rank[j] + 1'b1;
      end
    end
    new_valid[victim] = 1'b1;
    new_tag[victim]   = tag;
  end

endmodule
`default_nettype wire

// ===== hdl/set_assoc_lru_cache_tags.sv =====
// load and store: the set row is read at the accepting edge and the result is registered
// in ST_LOOK once the output is free, then the next transaction can be accepted in ST_IDLE;
// modify gives a second result from ST_LOOK2. no access is taken before the last one is done.
// rst is synchronous; after it a clearing pass over all 2**MAX_SET_BITS rows zeroes valid
// bits and ages, with s_tready low; configuration writes are taken throughout
`default_nettype none
module set_assoc_lru_cache_tags #(
  parameter int unsigned MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = salc_pkg::DEF_MAX_WAYS,
  parameter int unsigned ADDR_WIDTH   = salc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // address
  input  logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] s_tdata,
  // kind
  input  logic [salc_pkg::KIND_W-1:0]           s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // hit, evicted, hits_total, misses_total, evictions_total, zero pad
  output logic [salc_pkg::OUT_DATA_W-1:0]       m_tdata,
  output logic                                  m_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]          paddr,
  input  logic [salc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [salc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned DEPTH  = 2 ** MAX_SET_BITS;
  localparam int unsigned W_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int unsigned TAGS_W = MAX_WAYS * ADDR_WIDTH;
  localparam int unsigned RANKS_W = MAX_WAYS * W_W;
  localparam int unsigned ROW_W  = MAX_WAYS + RANKS_W + TAGS_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_LOOK2 = 4'b1000
  } state_t;

  state_t state;

  logic [salc_pkg::SET_BITS_W-1:0] set_bits;
  logic [salc_pkg::WAYS_W-1:0]     ways_used;
  logic [salc_pkg::OFF_W-1:0]      offset_bits;
  logic                            cfg_wr;

  logic [salc_pkg::SET_BITS_W-1:0] set_bits_eff;
  logic [WCNT_W-1:0]               ways_eff;

  logic [SET_W-1:0]      clr_idx;
  logic [SET_W-1:0]      split_set;
  logic [ADDR_WIDTH-1:0] split_tag;
  logic [SET_W-1:0]      cur_set;
  logic [ADDR_WIDTH-1:0] cur_tag;
  logic                  cur_modify;

  logic                  in_acc;
  logic                  kind_ok;
  logic                  step;

  logic                  mem_we;
  logic [SET_W-1:0]      mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]      mem_rdata;
  logic [ROW_W-1:0]      fwd_row;
  logic [ROW_W-1:0]      cur_row;

  logic [MAX_WAYS-1:0]                 new_valid;
  logic [MAX_WAYS-1:0][W_W-1:0]        new_rank;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag;
  logic [ROW_W-1:0]                    new_row;
  salc_pkg::lookup_res_t               res;

  logic [salc_pkg::CNT_W-1:0] hits_cnt;
  logic [salc_pkg::CNT_W-1:0] misses_cnt;
  logic [salc_pkg::CNT_W-1:0] evicts_cnt;
  logic [salc_pkg::CNT_W-1:0] hits_cnt_next;
  logic [salc_pkg::CNT_W-1:0] misses_cnt_next;
  logic [salc_pkg::CNT_W-1:0] evicts_cnt_next;

  logic out_hit;
  logic out_evicted;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      ways_used   <= salc_pkg::WAYS_W'(1);
      offset_bits <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        salc_pkg::REG_SET_BITS:    set_bits    <= pwdata[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::REG_WAYS_USED:   ways_used   <= pwdata[salc_pkg::WAYS_W-1:0];
        salc_pkg::REG_OFFSET_BITS: offset_bits <= pwdata[salc_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      salc_pkg::REG_SET_BITS:
        prdata = salc_pkg::APB_DATA_W'(set_bits);
      salc_pkg::REG_WAYS_USED:
        prdata = salc_pkg::APB_DATA_W'(ways_used);
      salc_pkg::REG_OFFSET_BITS:
        prdata = salc_pkg::APB_DATA_W'(offset_bits);
      default:
        prdata = '0;
    endcase
  end

  assign set_bits_eff = (int'(set_bits) > MAX_SET_BITS) ?
                        salc_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits;

  always_comb begin
    priority if (ways_used == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_used) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_used);
    end
  end

  // address split at the input
  salc_addr_split #(
    .ADDR_WIDTH   (ADDR_WIDTH),
    .MAX_SET_BITS (MAX_SET_BITS),
    .SET_W        (SET_W)
  ) u_split (
    .address      (s_tdata[ADDR_WIDTH-1:0]),
    .offset_bits  (offset_bits),
    .set_bits_eff (set_bits_eff),
    .set_idx      (split_set),
    .tag          (split_tag)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign kind_ok  = (s_tuser == salc_pkg::KIND_LOAD) || (s_tuser == salc_pkg::KIND_STORE) ||
                    (s_tuser == salc_pkg::KIND_MODIFY);
  assign step     = ((state == ST_LOOK) || (state == ST_LOOK2)) && (!m_tvalid || m_tready);

  // set memory
  assign new_row   = {new_tag, new_rank, new_valid};
  assign mem_we    = (state == ST_CLEAR) || step;
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : cur_set;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : new_row;

  salc_set_mem #(
    .ADDR_W (SET_W),
    .DEPTH  (DEPTH),
    .DATA_W (ROW_W)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (in_acc),
    .raddr  (split_set),
    .rdata  (mem_rdata)
  );

  // second lookup of a modify sees the row just written
  assign cur_row = (state == ST_LOOK2) ? fwd_row : mem_rdata;

  salc_way_logic #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .MAX_WAYS   (MAX_WAYS),
    .W_W        (W_W),
    .WCNT_W     (WCNT_W)
  ) u_ways (
    .row_valid  (cur_row[MAX_WAYS-1:0]),
    .row_rank   (cur_row[MAX_WAYS+RANKS_W-1:MAX_WAYS]),
    .row_tag    (cur_row[ROW_W-1:MAX_WAYS+RANKS_W]),
    .tag        (cur_tag),
    .ways_eff   (ways_eff),
    .new_valid  (new_valid),
    .new_rank   (new_rank),
    .new_tag    (new_tag),
    .res        (res)
  );

  assign hits_cnt_next   = res.hit ? hits_cnt + 1'b1 : hits_cnt;
  assign misses_cnt_next = res.hit ? misses_cnt : misses_cnt + 1'b1;
  assign evicts_cnt_next = res.evicted ? evicts_cnt + 1'b1 : evicts_cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      hits_cnt   <= '0;
      misses_cnt <= '0;
      evicts_cnt <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (step) begin
        hits_cnt   <= hits_cnt_next;
        misses_cnt <= misses_cnt_next;
        evicts_cnt <= evicts_cnt_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && kind_ok) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (step) begin
            state <= cur_modify ? ST_LOOK2 : ST_IDLE;
          end
        end
        ST_LOOK2: begin
          if (step) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_set    <= split_set;
      cur_tag    <= split_tag;
      cur_modify <= (s_tuser == salc_pkg::KIND_MODIFY);
    end
    if (step) begin
      fwd_row     <= new_row;
      out_hit     <= res.hit;
      out_evicted <= res.evicted;
      m_tlast     <= (state == ST_LOOK2) || !cur_modify;
    end
  end

  assign m_tdata = {{salc_pkg::OUT_PAD_W{1'b0}}, evicts_cnt, misses_cnt, hits_cnt,
                    out_evicted, out_hit};

endmodule
`default_nettype wire

// ===== hdl/salc_checker.sv =====
`default_nettype none
module salc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [salc_pkg::KIND_W-1:0]     s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [salc_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic                            m_tlast
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // a hit never evicts
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("hit with eviction");

  // second result of a modify follows at once, hits and closes the access
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[0] && m_tlast)
    else $error("modify second lookup wrong");

  // one access at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == salc_pkg::KIND_LOAD || s_tuser == salc_pkg::KIND_STORE ||
     s_tuser == salc_pkg::KIND_MODIFY) |=> !s_tready)
    else $error("input taken during lookup");

  // clearing pass after reset
  assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ready during clearing pass");

endmodule

bind set_assoc_lru_cache_tags salc_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire
